### sv/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// Types, constants and date arithmetic shared by the day count convention block.
// ----------------------------------------------------------------------------
package dcc_pkg;

   localparam int DayW   = 5;
   localparam int MonW   = 4;
   localparam int YearW  = 14;
   localparam int CountW = 22;
   localparam int BaseW  = 9;
   localparam int SerW   = 25;

   localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

   typedef enum logic [2:0] {
      CONV_ACTUAL     = 3'd0,
      CONV_30_360     = 3'd1,
      CONV_30E_360    = 3'd2,
      CONV_30EI_360   = 3'd3,
      CONV_30EP_360   = 3'd4,
      CONV_ACT_SPLIT  = 3'd5
   } conv_type;

   localparam logic [DayW-1:0] MONTH_LEN [16] = '{
      5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
   };

   // Month offset correction, (4*M+23)/10 for months after February.
   localparam logic [3:0] MONTH_ADJ [16] = '{
      4'd0, 4'd0, 4'd0, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5,
      4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd8
   };

   // Exact quotient by 100 for any 14-bit value, by reciprocal multiplication.
   function automatic logic [7:0] div100(input logic [YearW-1:0] v);
      logic [26:0] prod;
      prod = 27'(v) * 27'(5243);
      return prod[26:19];
   endfunction

   function automatic logic is_leap(input logic [YearW-1:0] y);
      logic [7:0] q;
      q = div100(y);
      return (y[1:0] == 2'b00) && ((y != YearW'(q) * YearW'(100)) || (q[1:0] == 2'b00));
   endfunction

   function automatic logic [DayW-1:0] last_day(input logic [MonW-1:0] m,
                                                input logic         leap);
      logic [DayW-1:0] d;
      d = MONTH_LEN[m];
      if (m == MonW'(2)) begin
         d = d + DayW'(leap);
      end
      return d;
   endfunction

   function automatic logic signed [SerW-1:0] serial_day(input logic [DayW-1:0]  d,
                                                         input logic [MonW-1:0]  m,
                                                         input logic [YearW-1:0] y);
      logic             early;
      logic [YearW-1:0] yp;
      logic [7:0]       q;
      logic [12:0]      t;
      logic [SerW-1:0]  s;
      early = (m <= MonW'(2));
      yp    = early ? (y - YearW'(1)) : y;
      q     = div100(yp);
      if (early && (y == '0)) begin
         t = '0;
      end else begin
         t = 13'(yp >> 2) - 13'(q) + 13'(q >> 2);
      end
      s = SerW'(y) * SerW'(365) + SerW'(m) * SerW'(31) + SerW'(d) + SerW'(t)
          - SerW'(MONTH_ADJ[m]) - SerW'(31);
      return $signed(s);
   endfunction

   function automatic logic [CountW-1:0] sat_count(input logic signed [SerW-1:0] v);
      logic [CountW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(SerW'(CountMax))) begin
         r = CountMax;
      end else begin
         r = v[CountW-1:0];
      end
      return r;
   endfunction

endpackage

### sv/day_count_convention.sv
// ----------------------------------------------------------------------------
// day_count_convention
// Interest day count between two calendar dates under a selectable convention.
// ----------------------------------------------------------------------------
// Usage: each req transaction carries a start and an end date. The block
// answers with one rsp transaction holding the day count, the second part
// and both year bases for the split actual/actual mode, and a flag in tuser
// that is set when the start is not earlier than the end.
// The convention register is written over the csr channel, which is always
// ready; it must only be changed while no transaction is in flight.
// The block has one input register and one result register with the date
// arithmetic between them. rsp_tvalid rises once the accepted req
// transaction has passed the input register into the result register.
// A new transaction can be accepted every cycle while rsp_tready is high.
// When rsp_tready is low the result register holds and the input register
// can still take one more transaction; req_tready drops once both are full.
// Synchronous reset empties both stages and sets the convention to actual.
// ----------------------------------------------------------------------------
module day_count_convention
   import dcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_day, start_month, start_year, end_day, end_month, end_year, zero pad
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // day_count, day_count_second, year_base_first, year_base_second, zero pad
   output logic [63:0] rsp_tdata,
   // not_before
   output logic [0:0]  rsp_tuser
);

   logic [2:0]  conv_ff;
   logic [2:0]  conv_in;
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [45:0] in_data_ff;
   logic [45:0] in_data_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [61:0] out_data_ff;
   logic [61:0] out_data_in;
   logic        out_flag_ff;
   logic        out_flag_in;
   logic        advance;

   logic [DayW-1:0]  d1;
   logic [MonW-1:0]  m1;
   logic [YearW-1:0] y1;
   logic [DayW-1:0]  d2;
   logic [MonW-1:0]  m2;
   logic [YearW-1:0] y2;
   logic             earlier;
   logic             leap1;
   logic             leap2;
   logic [DayW-1:0]  e1;
   logic [DayW-1:0]  e2;
   logic [DayW-1:0]  d1a;
   logic [DayW-1:0]  d2a;
   logic [MonW:0]    m2a;
   logic [YearW:0]   y2a;
   logic signed [SerW-1:0] s1;
   logic signed [SerW-1:0] s2;
   logic signed [SerW-1:0] ye;
   logic signed [SerW-1:0] c30;
   logic signed [SerW-1:0] c1;
   logic signed [SerW-1:0] c2;
   logic [BaseW-1:0] b1;
   logic [BaseW-1:0] b2;

   assign csr_ready  = 1'b1;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff};
   assign rsp_tuser  = out_flag_ff;

   assign d1 = in_data_ff[4:0];
   assign m1 = in_data_ff[8:5];
   assign y1 = in_data_ff[22:9];
   assign d2 = in_data_ff[27:23];
   assign m2 = in_data_ff[31:28];
   assign y2 = in_data_ff[45:32];

   assign earlier = (y1 < y2) || ((y1 == y2) && (m1 < m2)) ||
                    ((y1 == y2) && (m1 == m2) && (d1 < d2));
   assign leap1 = is_leap(y1);
   assign leap2 = is_leap(y2);
   assign e1    = last_day(m1, leap1);
   assign e2    = last_day(m2, leap2);
   assign s1    = serial_day(d1, m1, y1);
   assign s2    = serial_day(d2, m2, y2);
   assign ye    = serial_day(DayW'(31), MonW'(12), y1);

   always_comb begin
      d1a = d1;
      d2a = d2;
      m2a = {1'b0, m2};
      y2a = {1'b0, y2};
      unique case (conv_ff)
         CONV_30_360: begin
            if ((d2 == e2) && (m2 == MonW'(2)) && (d1 == e1) && (m1 == MonW'(2))) begin
               d2a = DayW'(30);
            end
            if ((d1 == e1) && (m1 == MonW'(2))) begin
               d1a = DayW'(30);
            end
            if (d2 == DayW'(31)) begin
               d2a = DayW'(30);
            end
            if (d1 == DayW'(31)) begin
               d1a = DayW'(30);
            end
         end
         CONV_30E_360: begin
            if (d1 == DayW'(31)) begin
               d1a = DayW'(30);
            end
            if (d2 == DayW'(31)) begin
               d2a = DayW'(30);
            end
         end
         CONV_30EI_360: begin
            if (d1 == e1) begin
               d1a = DayW'(30);
            end
            if ((d2 == e2) && (m2 != MonW'(2))) begin
               d2a = DayW'(30);
            end
         end
         CONV_30EP_360: begin
            if (d1 == DayW'(31)) begin
               d1a = DayW'(30);
            end
            if (d2 == DayW'(31)) begin
               d2a = DayW'(1);
               if (m2 >= MonW'(12)) begin
                  m2a = (MonW+1)'(1);
                  y2a = (YearW+1)'(y2) + (YearW+1)'(1);
               end else begin
                  m2a = (MonW+1)'(m2) + (MonW+1)'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign c30 = (SerW'(d2a) - SerW'(d1a)) + (SerW'(m2a) - SerW'(m1)) * SerW'(30)
                + (SerW'(y2a) - SerW'(y1)) * SerW'(360);

   always_comb begin
      c1 = '0;
      c2 = '0;
      b1 = '0;
      b2 = '0;
      if (earlier) begin
         unique case (conv_ff)
            CONV_30_360, CONV_30E_360, CONV_30EI_360, CONV_30EP_360: begin
               c1 = c30;
            end
            CONV_ACT_SPLIT: begin
               if ((y1 != y2) && (leap1 != leap2)) begin
                  b1 = BaseW'(365) + BaseW'(leap1);
                  b2 = BaseW'(365) + BaseW'(leap2);
                  c1 = ye - s1 + SerW'(1);
                  c2 = s2 - ye;
               end else begin
                  c1 = s2 - s1;
               end
            end
            default: begin
               c1 = s2 - s1;
            end
         endcase
      end
   end

   always_comb begin
      conv_in      = conv_ff;
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_flag_in  = out_flag_ff;
      if (csr_valid && csr_ready) begin
         conv_in = csr_data;
      end
      if (advance) begin
         out_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
         if (in_valid_ff) begin
            out_data_in = {b2, b1, sat_count(c2), sat_count(c1)};
            out_flag_in = !earlier;
         end
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_tdata[45:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_ff      <= CONV_ACTUAL;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         conv_ff      <= conv_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
      out_flag_ff <= out_flag_in;
   end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the day count convention block.
// A short table of date pairs covers the extremes, every convention and the
// odd cases: equal or reversed dates, months out of range, negative and
// saturated counts, the month roll and the split at year end. It is followed
// by random date pairs under every convention and under several traffic
// patterns, with a long hold on the result side that fills the pipeline.
// Each result transaction is checked field by field against the expected
// counts of its table row or against a predictor of the block kept in this file.
// ----------------------------------------------------------------------------
module testbench;
   import dcc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CONV_SPARE_6 = 3'd6;
   localparam logic [2:0] CONV_SPARE_7 = 3'd7;

   localparam int DirectedRows   = 25;
   localparam int RandomPhases   = 10;
   localparam int PhaseItems     = 160;
   localparam int SettleCycles   = 4;
   localparam int DrainCycles    = 8;
   localparam int PressureCycles = 64;
   localparam int WatchdogLimit  = 3000;

   typedef struct packed {
      logic [DayW-1:0]  start_day;
      logic [MonW-1:0]  start_month;
      logic [YearW-1:0] start_year;
      logic [DayW-1:0]  end_day;
      logic [MonW-1:0]  end_month;
      logic [YearW-1:0] end_year;
   } dates_type;

   localparam int DatesW = $bits(dates_type);

   typedef struct packed {
      logic [CountW-1:0] days;
      logic [CountW-1:0] days_after;
      logic [BaseW-1:0]  base_first;
      logic [BaseW-1:0]  base_second;
      logic              not_before;
   } day_count_type;

   localparam day_count_type NoCount = '0;

   typedef struct packed {
      logic [2:0]    conv;
      dates_type     dates;
      logic          known;
      day_count_type result;
   } directed_row_type;

   typedef enum logic [2:0] {
      TRAFFIC_STEADY,
      TRAFFIC_SPARSE_SEND,
      TRAFFIC_SLOW_SINK,
      TRAFFIC_BOTH,
      TRAFFIC_BACKPRESSURE
   } traffic_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   logic [2:0]    active_conv  = CONV_ACTUAL;
   traffic_type   traffic_mode = TRAFFIC_STEADY;
   day_count_type pending_counts [$];
   int unsigned   mismatches   = 0;
   int unsigned   quiet_cycles = 0;

   directed_row_type directed [DirectedRows] = '{
      '{CONV_ACTUAL,    '{1, 1, 2000, 1, 1, 2001},      1'b1, '{366, 0, 0, 0, 0}},
      '{CONV_ACTUAL,    '{15, 6, 2024, 15, 6, 2024},    1'b1, '{0, 0, 0, 0, 1}},
      '{CONV_ACTUAL,    '{0, 0, 0, 31, 15, 16383},      1'b1, '{CountMax, 0, 0, 0, 0}},
      '{CONV_ACTUAL,    '{1, 1, 1, 31, 12, 9999},       1'b0, NoCount},
      '{CONV_ACTUAL,    '{31, 2, 2001, 0, 3, 2001},     1'b1, '{0, 0, 0, 0, 0}},
      '{CONV_ACTUAL,    '{31, 15, 2000, 0, 0, 2001},    1'b0, NoCount},
      '{CONV_30_360,    '{28, 2, 2001, 28, 2, 2002},    1'b0, NoCount},
      '{CONV_30_360,    '{29, 2, 2004, 31, 3, 2004},    1'b0, NoCount},
      '{CONV_30_360,    '{31, 1, 2003, 31, 3, 2003},    1'b0, NoCount},
      '{CONV_30_360,    '{1, 1, 0, 1, 1, 16383},        1'b1, '{CountMax, 0, 0, 0, 0}},
      '{CONV_30E_360,   '{31, 1, 2003, 31, 5, 2003},    1'b0, NoCount},
      '{CONV_30E_360,   '{30, 4, 2003, 31, 12, 2003},   1'b0, NoCount},
      '{CONV_30EI_360,  '{29, 2, 2004, 28, 2, 2005},    1'b0, NoCount},
      '{CONV_30EI_360,  '{30, 4, 2005, 31, 5, 2005},    1'b0, NoCount},
      '{CONV_30EI_360,  '{28, 2, 2005, 29, 2, 2008},    1'b0, NoCount},
      '{CONV_30EP_360,  '{31, 1, 2005, 31, 12, 2005},   1'b0, NoCount},
      '{CONV_30EP_360,  '{1, 1, 16383, 31, 12, 16383},  1'b0, NoCount},
      '{CONV_30EP_360,  '{15, 7, 2005, 31, 13, 2005},   1'b0, NoCount},
      '{CONV_ACT_SPLIT, '{15, 6, 2003, 15, 3, 2004},    1'b0, NoCount},
      '{CONV_ACT_SPLIT, '{31, 12, 2004, 1, 1, 2005},    1'b0, NoCount},
      '{CONV_ACT_SPLIT, '{1, 3, 2001, 1, 3, 2002},      1'b0, NoCount},
      '{CONV_ACT_SPLIT, '{1, 1, 2004, 31, 12, 2004},    1'b0, NoCount},
      '{CONV_ACT_SPLIT, '{1, 1, 2005, 31, 12, 2004},    1'b1, '{0, 0, 0, 0, 1}},
      '{CONV_SPARE_6,   '{1, 1, 2000, 1, 1, 2001},      1'b1, '{366, 0, 0, 0, 0}},
      '{CONV_SPARE_7,   '{2, 5, 2010, 1, 7, 2011},      1'b0, NoCount}
   };

   logic [2:0] phase_conv [RandomPhases] = '{
      CONV_ACTUAL, CONV_30_360, CONV_30E_360, CONV_30EI_360, CONV_30EP_360,
      CONV_ACT_SPLIT, CONV_SPARE_6, CONV_SPARE_7, CONV_ACT_SPLIT, CONV_ACTUAL
   };

   day_count_convention dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint leap_year(input longint y);
      return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 1 : 0;
   endfunction

   function automatic longint month_end(input longint m, input longint y);
      case (m)
         2: return 28 + leap_year(y);
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   // Day number since a fixed epoch; March is treated as the first month so
   // that the leap day falls at the end of the counting year.
   function automatic longint day_number(input longint d, input longint m, input longint y);
      longint prior;
      longint shift;
      longint extra;
      if (m <= 2) begin
         shift = 0;
         prior = y - 1;
      end else begin
         shift = (4 * m + 23) / 10;
         prior = y;
      end
      extra = (prior < 0) ? 0 : (prior / 4 - prior / 100 + prior / 400);
      return 365 * y + 31 * (m - 1) + d + extra - shift;
   endfunction

   function automatic logic [CountW-1:0] clamp_count(input longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > longint'(CountMax)) begin
         return CountMax;
      end
      return CountW'(v);
   endfunction

   function automatic day_count_type predict_day_count(input dates_type x,
                                                       input logic [2:0] conv);
      longint        d1, m1, y1, d2, m2, y2;
      longint        e1, e2, year_end, count, count_after;
      logic          earlier;
      day_count_type r;
      d1 = x.start_day;
      m1 = x.start_month;
      y1 = x.start_year;
      d2 = x.end_day;
      m2 = x.end_month;
      y2 = x.end_year;
      r = '0;
      count = 0;
      count_after = 0;
      earlier = (y1 < y2) || (y1 == y2 && m1 < m2) || (y1 == y2 && m1 == m2 && d1 < d2);
      r.not_before = !earlier;
      if (earlier) begin
         if (conv >= CONV_30_360 && conv <= CONV_30EP_360) begin
            e1 = month_end(m1, y1);
            e2 = month_end(m2, y2);
            case (conv)
               CONV_30_360: begin
                  if (d2 == e2 && m2 == 2 && d1 == e1 && m1 == 2) begin
                     d2 = 30;
                  end
                  if (d1 == e1 && m1 == 2) begin
                     d1 = 30;
                  end
                  if (d2 == 31) begin
                     d2 = 30;
                  end
                  if (d1 == 31) begin
                     d1 = 30;
                  end
               end
               CONV_30E_360: begin
                  if (d1 == 31) begin
                     d1 = 30;
                  end
                  if (d2 == 31) begin
                     d2 = 30;
                  end
               end
               CONV_30EI_360: begin
                  if (d1 == e1) begin
                     d1 = 30;
                  end
                  if (d2 == e2 && m2 != 2) begin
                     d2 = 30;
                  end
               end
               default: begin
                  if (d1 == 31) begin
                     d1 = 30;
                  end
                  if (d2 == 31) begin
                     d2 = 1;
                     m2 = m2 + 1;
                     if (m2 > 12) begin
                        m2 = 1;
                        y2 = y2 + 1;
                     end
                  end
               end
            endcase
            count = (d2 - d1) + ((m2 - m1) + (y2 - y1) * 12) * 30;
         end else if (conv == CONV_ACT_SPLIT && y1 != y2 &&
                      leap_year(y1) != leap_year(y2)) begin
            year_end = day_number(31, 12, y1);
            r.base_first = BaseW'(365 + leap_year(y1));
            r.base_second = BaseW'(365 + leap_year(y2));
            count = year_end - day_number(d1, m1, y1) + 1;
            count_after = day_number(d2, m2, y2) - year_end;
         end else begin
            count = day_number(d2, m2, y2) - day_number(d1, m1, y1);
         end
      end
      r.days = clamp_count(count);
      r.days_after = clamp_count(count_after);
      return r;
   endfunction

   function automatic logic [DayW-1:0] pick_day(input logic [MonW-1:0] m,
                                               input logic [YearW-1:0] y);
      longint last;
      last = month_end(m, y);
      case ($urandom_range(0, 3))
         0: return DayW'(last);
         1: return DayW'(1);
         default: return DayW'($urandom_range(1, int'(last)));
      endcase
   endfunction

   // Mostly well-formed date pairs a few years apart; some equal or reversed
   // pairs, and raw bit patterns that reach every field value.
   function automatic dates_type random_dates();
      dates_type   x;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      x = DatesW'({$urandom(), $urandom()});
      if (pick >= 12) begin
         if (pick < 32) begin
            x.start_year = YearW'($urandom_range(1, 9999));
         end else begin
            x.start_year = YearW'($urandom_range(1890, 2110));
         end
         x.start_month = MonW'($urandom_range(1, 12));
         x.start_day = pick_day(x.start_month, x.start_year);
         if (pick < 17) begin
            x.end_year = x.start_year;
            x.end_month = x.start_month;
            x.end_day = x.start_day;
         end else begin
            if (pick < 22) begin
               x.end_year = x.start_year - YearW'(1);
            end else begin
               x.end_year = x.start_year + YearW'($urandom_range(0, 2));
            end
            x.end_month = MonW'($urandom_range(1, 12));
            x.end_day = pick_day(x.end_month, x.end_year);
         end
      end
      return x;
   endfunction

   function automatic int unsigned idle_percent(input bit sink);
      case (traffic_mode)
         TRAFFIC_SPARSE_SEND: return sink ? 0 : 86;
         TRAFFIC_SLOW_SINK: return sink ? 86 : 0;
         TRAFFIC_BOTH: return 26;
         default: return 0;
      endcase
   endfunction

   task automatic send_dates(input dates_type x, input logic known,
                             input day_count_type typed);
      while ($urandom_range(0, 99) < idle_percent(1'b0)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, x.end_year, x.end_month, x.end_day,
                    x.start_year, x.start_month, x.start_day};
      do @(posedge clock); while (!req_tready);
      pending_counts.push_back(known ? typed : predict_day_count(x, active_conv));
   endtask

   task automatic write_convention(input logic [2:0] conv);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= conv;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_conv = conv;
   endtask

   task automatic check_field(input string what, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   initial begin
      int         row;
      int         phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (row = 0; row < DirectedRows; row++) begin
         if (directed[row].conv != active_conv) begin
            req_tvalid <= 1'b0;
            write_convention(directed[row].conv);
         end
         send_dates(directed[row].dates, directed[row].known, directed[row].result);
      end
      for (phase = 0; phase < RandomPhases; phase++) begin
         req_tvalid <= 1'b0;
         write_convention(phase_conv[phase]);
         traffic_mode = traffic_type'(phase % 5);
         repeat (PhaseItems) send_dates(random_dates(), 1'b0, NoCount);
      end
      req_tvalid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && pending_counts.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      int unsigned   hold_left;
      bit            pressure_done;
      day_count_type want;
      hold_left = 0;
      pressure_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (traffic_mode == TRAFFIC_BACKPRESSURE && !pressure_done) begin
            hold_left = PressureCycles;
            pressure_done = 1'b1;
         end else if (traffic_mode != TRAFFIC_BACKPRESSURE) begin
            pressure_done = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= idle_percent(1'b1));
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_counts.size() == 0) begin
               mismatches++;
               $display("%0t: result transaction mismatch, expected none, actual %h / %b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = pending_counts.pop_front();
               check_field("day_count", want.days, rsp_tdata[CountW-1:0]);
               check_field("day_count_second", want.days_after,
                           rsp_tdata[2*CountW-1:CountW]);
               check_field("year_base_first", want.base_first,
                           rsp_tdata[2*CountW+BaseW-1:2*CountW]);
               check_field("year_base_second", want.base_second,
                           rsp_tdata[2*CountW+2*BaseW-1:2*CountW+BaseW]);
               check_field("not_before", want.not_before, rsp_tuser[0]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
